FILE: hw/rtl/searchable_stack_engine_top_defines.svh
// ----------------------------------------------------------------------------
// searchable stack engine assertion macros
// shared property forms for the stack engine checks
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_STACK_ENGINE_TOP_DEFINES_SVH
`define SEARCHABLE_STACK_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack engine check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack engine check failed");

`endif

FILE: hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// shared types and codes of the searchable stack engine
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned DefDepth    = 256;
  localparam int unsigned DefWordBits = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned OpW         = 4;

  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_PEEK    = 4'd2,
    OP_READ    = 4'd3,
    OP_WRITE   = 4'd4,
    OP_SEARCH  = 4'd5,
    OP_REM_IDX = 4'd6,
    OP_REM_VAL = 4'd7,
    OP_DROP    = 4'd8,
    OP_SET_CNT = 4'd9,
    OP_CLEAR   = 4'd10
  } op_e;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic eval;
    logic wr;
    logic shift;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/searchable_stack_engine_top.sv
// ----------------------------------------------------------------------------
// searchable_stack_engine_top
// fixed-depth word stack with indexed access, search and removal
//
//   channel   signals                               transfer
//   command   start_i, opcode_i, value_i, index_i   start_i && !busy_o
//   result    done_o, status_o, data_o, count_o     done_o, one cycle
//
// a command passes S_EVAL, S_REDUCE and S_COMMIT up to the result strobe:
// the cells compare, the match and read taps are reduced, then the cells
// commit a write or a shift toward the bottom. busy_o drops in the strobe
// cycle, so a new command can transfer in that cycle. reset clears every
// cell at once, no clearing pass. the result side cannot stall.
// ----------------------------------------------------------------------------
`include "searchable_stack_engine_top_defines.svh"

module searchable_stack_engine_top import sse_pkg::*; #(
  parameter int unsigned Depth    = DefDepth,
  parameter int unsigned WordBits = DefWordBits,
  localparam int unsigned CntW    = $clog2(Depth + 1),
  localparam int unsigned PosW    = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [WordBits-1:0] value_i,
  input  logic [CntW-1:0]     index_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [StatusW-1:0]  status_o,
  output logic [DataW-1:0]    data_o,
  output logic [CntW-1:0]     count_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                done_q;
  op_e                 op_q;
  logic [WordBits-1:0] val_q;
  logic [CntW-1:0]     idx_q;
  logic                hit_q;
  logic [PosW-1:0]     last_q;
  logic [WordBits-1:0] rd_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [WordBits-1:0] data_q, data_d;

  logic                accept;
  cell_cmd_t           cmd;
  logic [CntW-1:0]     pos, sel_pos, cpos;
  logic                wr_c, sh_c;
  logic                any_hit;
  logic [PosW-1:0]     last_hit;
  logic [WordBits-1:0] rd_or;
  logic                idx_miss, empty;

  logic [WordBits-1:0] word_w [Depth];
  logic [WordBits-1:0] tap_w  [Depth];
  logic [Depth-1:0]    match_w;

  assign accept = start_i && (state_q == S_IDLE);

  // cell row
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [WordBits-1:0] nbr;
    if (g == Depth - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = word_w[g+1];
    end
    sse_cell #(
      .WordBits(WordBits),
      .CntW    (CntW),
      .Pos     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .val_i  (val_q),
      .pos_i  (pos),
      .cnt_i  (count_q),
      .nbr_i  (nbr),
      .word_o (word_w[g]),
      .match_o(match_w[g]),
      .tap_o  (tap_w[g])
    );
  end

  always_comb begin
    sel_pos = count_q - CntW'(1);
    if (op_q == OP_READ) begin
      sel_pos = idx_q;
    end
  end

  // reduce match flags and read taps
  always_comb begin
    any_hit  = 1'b0;
    last_hit = '0;
    rd_or    = '0;
    for (int i = 0; i < Depth; i++) begin
      if (match_w[i]) begin
        any_hit  = 1'b1;
        last_hit = PosW'(i);
      end
      rd_or = rd_or | tap_w[i];
    end
  end

  // commit decision
  always_comb begin
    idx_miss = (idx_q >= count_q);
    empty    = (count_q == '0);
    status_d = ST_OK;
    data_d   = '0;
    count_d  = count_q;
    wr_c     = 1'b0;
    sh_c     = 1'b0;
    cpos     = idx_q;
    case (op_q)
      OP_PUSH: begin
        if (count_q >= CntW'(Depth)) begin
          status_d = ST_FULL;
        end else begin
          wr_c    = 1'b1;
          cpos    = count_q;
          count_d = count_q + CntW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_MISS;
        end else begin
          data_d  = rd_q;
          count_d = count_q - CntW'(1);
        end
      end
      OP_PEEK: begin
        if (empty) status_d = ST_MISS;
        else data_d = rd_q;
      end
      OP_READ: begin
        if (idx_miss) status_d = ST_MISS;
        else data_d = rd_q;
      end
      OP_WRITE: begin
        if (idx_miss) status_d = ST_MISS;
        else wr_c = 1'b1;
      end
      OP_SEARCH: begin
        status_d = hit_q ? ST_OK : ST_MISS;
      end
      OP_REM_IDX: begin
        if (idx_miss) begin
          status_d = ST_MISS;
        end else begin
          sh_c    = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      OP_REM_VAL: begin
        if (hit_q) begin
          sh_c    = 1'b1;
          cpos    = CntW'(last_q);
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_DROP: begin
        count_d = idx_miss ? '0 : (count_q - idx_q);
      end
      OP_SET_CNT: begin
        count_d = (idx_q > CntW'(Depth)) ? CntW'(Depth) : idx_q;
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  assign cmd.eval  = (state_q == S_EVAL);
  assign cmd.wr    = (state_q == S_COMMIT) && wr_c;
  assign cmd.shift = (state_q == S_COMMIT) && sh_c;
  assign pos       = (state_q == S_COMMIT) ? cpos : sel_pos;

  always_comb begin
    case (state_q)
      S_IDLE:   state_d = accept ? S_EVAL : S_IDLE;
      S_EVAL:   state_d = S_REDUCE;
      S_REDUCE: state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_COMMIT);
      if (state_q == S_COMMIT) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
    if (state_q == S_REDUCE) begin
      hit_q  <= any_hit;
      last_q <= last_hit;
      rd_q   <= rd_or;
    end
    if (state_q == S_COMMIT) begin
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = DataW'(data_q);
  assign count_o  = count_q;

  `SSE_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `SSE_ASSERT_NEXT(a_commit_strobe, state_q == S_COMMIT, done_o && !busy_o)
  `SSE_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o)
  `SSE_ASSERT_IMPL(a_full_push, done_o && (status_o == ST_FULL), op_q == OP_PUSH)

endmodule

FILE: hw/rtl/sse_cell.sv
// ----------------------------------------------------------------------------
// sse_cell
// one stack entry: holds a word, compares it, loads or takes its neighbor
// ----------------------------------------------------------------------------
module sse_cell import sse_pkg::*; #(
  parameter int unsigned WordBits = DefWordBits,
  parameter int unsigned CntW     = 9,
  parameter int unsigned Pos      = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_cmd_t           cmd_i,
  input  logic [WordBits-1:0] val_i,
  input  logic [CntW-1:0]     pos_i,
  input  logic [CntW-1:0]     cnt_i,
  input  logic [WordBits-1:0] nbr_i,
  output logic [WordBits-1:0] word_o,
  output logic                match_o,
  output logic [WordBits-1:0] tap_o
);

  logic [WordBits-1:0] word_q, word_d;
  logic                match_q;
  logic [WordBits-1:0] tap_q;
  logic                here, in_use, at_or_above, below_top;

  assign here        = (CntW'(Pos) == pos_i);
  assign in_use      = (CntW'(Pos) < cnt_i);
  assign at_or_above = (CntW'(Pos) >= pos_i);
  assign below_top   = (CntW'(Pos + 1) < cnt_i);

  always_comb begin
    word_d = word_q;
    if (cmd_i.wr && here) begin
      word_d = val_i;
    end else if (cmd_i.shift && at_or_above && below_top) begin
      word_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      match_q <= in_use && (word_q == val_i);
      tap_q   <= here ? word_q : '0;
    end
  end

  assign word_o  = word_q;
  assign match_o = match_q;
  assign tap_o   = tap_q;

endmodule
